// ===== rtl/fwdm_pkg.sv =====
// Shared types and constants for the four-wheel mecanum drive mixer.
`default_nettype none

package fwdm_pkg;

    localparam int WHEELS      = 4;
    localparam int AXIS_W      = 8;
    localparam int SHAPED_W    = 10;   // scaled axis, -257 .. 257
    localparam int SUM_W       = 11;   // wheel sum, -771 .. 771
    localparam int MAG_W       = 10;   // wheel magnitude, 0 .. 771
    localparam int QUO_BITS    = 8;    // normalized magnitude, 0 .. 255
    localparam int NUM_W       = 18;   // magnitude * 255
    localparam int PERIOD_W    = 17;   // pwm_period_top + 1
    localparam int PROD_W      = 24;   // normalized magnitude * period
    localparam int CMP_W       = 17;
    localparam int DB_W        = 7;
    localparam int TOP_W       = 16;

    localparam int FULL_SCALE  = 255;
    localparam int AXIS_SCALE  = 127;

    // x / 255 == (x * RECIP_255) >> RECIP_SHIFT for every x below 2^24
    localparam logic [PROD_W-1:0] RECIP_255   = 24'h808081;
    localparam int                RECIP_SHIFT = 31;

    localparam logic [DB_W-1:0]  DEADBAND_RST = 7'd20;
    localparam logic [TOP_W-1:0] PERIOD_RST   = 16'd999;

    typedef enum logic {
        REG_DEADBAND   = 1'b0,
        REG_PERIOD_TOP = 1'b1
    } reg_sel_t;

    typedef struct packed {
        logic [DB_W-1:0]  deadband;
        logic [TOP_W-1:0] period_top;
    } cfg_t;

    // one classified command waiting for the back end
    typedef struct packed {
        logic [WHEELS-1:0]            pos;
        logic [WHEELS-1:0][MAG_W-1:0] mag;
        logic [MAG_W-1:0]             den;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [WHEELS-1:0]            fwd;
        logic [WHEELS-1:0][CMP_W-1:0] cmp;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/fwdm_front.sv =====
// Front end: deadband, axis scaling, mecanum sums, magnitudes and divisor.
`default_nettype none

module fwdm_front import fwdm_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [AXIS_W-1:0] forward_axis,
    input  logic signed [AXIS_W-1:0] strafe_axis,
    input  logic signed [AXIS_W-1:0] turn_axis,
    input  logic [DB_W-1:0]          deadband,
    output logic                     out_valid,
    output cmd_t                     out_cmd
);

    function automatic logic signed [SHAPED_W-1:0] shape(
        input logic signed [AXIS_W-1:0] a,
        input logic [DB_W-1:0]          db
    );
        logic signed [AXIS_W:0] ax;
        logic [AXIS_W:0]        m;
        logic [AXIS_W:0]        s;
        ax = {a[AXIS_W-1], a};
        m  = ax[AXIS_W] ? (AXIS_W+1)'(-ax) : (AXIS_W+1)'(ax);
        if (m < (AXIS_W+1)'(db)) begin
            m = '0;
        end
        // m * 255 / 127 == 2m + (m >= 127) for m up to 128
        s = {m[AXIS_W-1:0], 1'b0} + (AXIS_W+1)'(m >= (AXIS_W+1)'(AXIS_SCALE));
        return a[AXIS_W-1] ? -$signed({1'b0, s}) : $signed({1'b0, s});
    endfunction

    logic [1:0]                  vld_reg, vld_next;
    logic signed [SHAPED_W-1:0]  f_reg, s_reg, t_reg;
    cmd_t                        cmd_reg, cmd_next;

    logic signed [SUM_W-1:0]           f_x, s_x, t_x;
    logic signed [WHEELS-1:0][SUM_W-1:0] w;
    logic [MAG_W-1:0]                  max_a, max_b, max_all;

    assign vld_next = {vld_reg[0], in_valid};

    always_comb begin
        f_x = SUM_W'(f_reg);
        s_x = SUM_W'(s_reg);
        t_x = SUM_W'(t_reg);
        w[0] =  f_x + s_x + t_x;
        w[1] =  f_x - s_x - t_x;
        w[2] = -f_x - s_x + t_x;
        w[3] = -f_x + s_x - t_x;
        for (int j = 0; j < WHEELS; j++) begin
            // an element of the packed array reads as unsigned
            cmd_next.pos[j] = ($signed(w[j]) > 0);
            cmd_next.mag[j] = w[j][SUM_W-1] ? MAG_W'(-w[j]) : MAG_W'(w[j]);
        end
        max_a   = (cmd_next.mag[0] > cmd_next.mag[1]) ? cmd_next.mag[0] : cmd_next.mag[1];
        max_b   = (cmd_next.mag[2] > cmd_next.mag[3]) ? cmd_next.mag[2] : cmd_next.mag[3];
        max_all = (max_a > max_b) ? max_a : max_b;
        // below full scale divide by 255 itself, which leaves the magnitude as is
        cmd_next.den = (max_all > MAG_W'(FULL_SCALE)) ? max_all : MAG_W'(FULL_SCALE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_reg   <= shape(forward_axis, deadband);
            s_reg   <= shape(strafe_axis, deadband);
            t_reg   <= shape(turn_axis, deadband);
            cmd_reg <= cmd_next;
        end
    end

    assign out_valid = vld_reg[1];
    assign out_cmd   = cmd_reg;

endmodule

`default_nettype wire

// ===== rtl/fwdm_queue.sv =====
// Short command queue between front end and back end.
`default_nettype none

module fwdm_queue import fwdm_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    pop_cmd,
    output q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

`default_nettype wire

// ===== rtl/fwdm_back.sv =====
// Back end: normalizing divider lanes, PWM compare scaling and output skid buffer.
`default_nettype none

module fwdm_back import fwdm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  q_stat_t          q_stat,
    input  cmd_t             q_cmd,
    output logic             q_pop,
    input  logic [TOP_W-1:0] period_top,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res
);

    // stages 0..QUO_BITS divide, then product, then compare
    localparam int PROD_ST = QUO_BITS + 1;
    localparam int LAST    = QUO_BITS + 2;

    logic                  en;
    logic [LAST:0]         vld_reg, vld_next;

    logic [WHEELS-1:0][NUM_W-1:0]    rem_reg  [QUO_BITS+1];
    logic [WHEELS-1:0][NUM_W-1:0]    rem_next [QUO_BITS+1];
    logic [WHEELS-1:0][QUO_BITS-1:0] quo_reg  [QUO_BITS+1];
    logic [WHEELS-1:0][QUO_BITS-1:0] quo_next [QUO_BITS+1];
    logic [MAG_W-1:0]                den_reg  [QUO_BITS+1];
    logic [WHEELS-1:0]               pos_reg  [LAST+1];

    logic [PERIOD_W-1:0]             period;
    logic [WHEELS-1:0][PROD_W-1:0]   prod_reg, prod_next;
    logic [WHEELS-1:0][CMP_W-1:0]    cmp_reg, cmp_next;
    logic [2*PROD_W-1:0]             recip_prod [WHEELS];

    res_t  last_res;
    res_t  out_reg, skid_reg;
    logic  out_vld_reg, skid_vld_reg;
    logic  push_out;

    // advance the whole pipe while the skid stage is free
    assign en       = !skid_vld_reg;
    assign q_pop    = en && !q_stat.empty;
    assign vld_next = {vld_reg[LAST-1:0], q_pop};
    assign period   = PERIOD_W'(period_top) + 1'b1;

    always_comb begin
        for (int j = 0; j < WHEELS; j++) begin
            rem_next[0][j] = (NUM_W'(q_cmd.mag[j]) << 8) - NUM_W'(q_cmd.mag[j]);
            quo_next[0][j] = '0;
        end
        for (int k = 1; k <= QUO_BITS; k++) begin
            for (int j = 0; j < WHEELS; j++) begin
                rem_next[k][j] = rem_reg[k-1][j];
                quo_next[k][j] = quo_reg[k-1][j];
                if (rem_reg[k-1][j] >= (NUM_W'(den_reg[k-1]) << (QUO_BITS - k))) begin
                    rem_next[k][j] = rem_reg[k-1][j]
                                   - (NUM_W'(den_reg[k-1]) << (QUO_BITS - k));
                    quo_next[k][j][QUO_BITS-k] = 1'b1;
                end
            end
        end
        for (int j = 0; j < WHEELS; j++) begin
            prod_next[j]  = PROD_W'(quo_reg[QUO_BITS][j]) * PROD_W'(period);
            recip_prod[j] = (2*PROD_W)'(prod_reg[j]) * (2*PROD_W)'(RECIP_255);
            cmp_next[j]   = recip_prod[j][RECIP_SHIFT+CMP_W-1:RECIP_SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0] <= q_cmd.den;
            pos_reg[0] <= q_cmd.pos;
            for (int k = 0; k <= QUO_BITS; k++) begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
            for (int k = 1; k <= QUO_BITS; k++) begin
                den_reg[k] <= den_reg[k-1];
            end
            for (int k = 1; k <= LAST; k++) begin
                pos_reg[k] <= pos_reg[k-1];
            end
            prod_reg <= prod_next;
            cmp_reg  <= cmp_next;
        end
    end

    assign last_res.fwd = pos_reg[LAST];
    assign last_res.cmp = cmp_reg;
    assign push_out     = en && vld_reg[LAST];

    // output register with a skid stage behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (res_ready) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (push_out) begin
            if (!out_vld_reg || res_ready) begin
                out_vld_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (res_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (res_ready) begin
                out_reg <= skid_reg;
            end
        end else if (push_out) begin
            if (!out_vld_reg || res_ready) begin
                out_reg <= last_res;
            end else begin
                skid_reg <= last_res;
            end
        end
    end

    assign res_valid = out_vld_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

// ===== rtl/four_wheel_drive_mixer.sv =====
// Mecanum four-wheel mixer: top level with configuration registers.
//
// Input items arrive on s_tvalid/s_tready/s_tdata, one stick command each
// (forward, strafe and turn axes). Every item yields exactly one result item
// on m_tvalid/m_tready/m_tdata with a direction bit and a PWM compare value
// for each of the four wheels.
// The block takes one item per cycle while s_tready is high. With nothing
// stalled, an item goes from the accepting edge to m_tvalid through: the first
// of two front stages, loaded by the accepting edge; the second front stage;
// the command queue; one load stage and eight stages of the normalizing divider
// (one quotient bit each); one stage for magnitude times period; one for the
// reciprocal multiply that divides by 255; and the output register.
// The front end stops taking items only when the command queue is full; the
// back end stops only when its output skid stage is occupied. A stalled
// receiver therefore fills the output stage, then the queue, and only then
// drops s_tready. No item is lost or repeated across a stall.
// Reset empties every stage and the queue and loads deadband 20 and PWM period
// top 999. Registers sit on an APB port (deadband at 0x0, period top at 0x4).
// Write them only while no item is in flight; the block does not enforce this.
`default_nettype none

module four_wheel_drive_mixer import fwdm_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // forward_axis [7:0], strafe_axis [15:8], turn_axis [23:16]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // wheel1_forward [0], wheel1_compare [17:1], wheel2_forward [18],
    // wheel2_compare [35:19], wheel3_forward [36], wheel3_compare [53:37],
    // wheel4_forward [54], wheel4_compare [71:55]
    output logic [71:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t     cfg_reg;
    reg_sel_t sel;
    logic     wr_en;

    logic     front_en;
    logic     front_vld;
    cmd_t     front_cmd;
    cmd_t     q_cmd;
    q_stat_t  q_stat;
    logic     q_pop;
    logic     res_valid;
    res_t     res;

    assign pready = 1'b1;
    assign sel    = reg_sel_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deadband   <= DEADBAND_RST;
            cfg_reg.period_top <= PERIOD_RST;
        end else if (wr_en) begin
            unique case (sel)
                REG_DEADBAND:   cfg_reg.deadband   <= pwdata[DB_W-1:0];
                REG_PERIOD_TOP: cfg_reg.period_top <= pwdata[TOP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_DEADBAND:   prdata = 32'(cfg_reg.deadband);
            REG_PERIOD_TOP: prdata = 32'(cfg_reg.period_top);
            default:        prdata = '0;
        endcase
    end

    // front pipe runs freely until the queue fills
    assign front_en = !q_stat.full;
    assign s_tready = front_en;

    fwdm_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (front_en),
        .in_valid     (s_tvalid && s_tready),
        .forward_axis (s_tdata[7:0]),
        .strafe_axis  (s_tdata[15:8]),
        .turn_axis    (s_tdata[23:16]),
        .deadband     (cfg_reg.deadband),
        .out_valid    (front_vld),
        .out_cmd      (front_cmd)
    );

    fwdm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (front_en && front_vld),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_cmd),
        .stat     (q_stat)
    );

    fwdm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .period_top (cfg_reg.period_top),
        .res_valid  (res_valid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {res.cmp[3], res.fwd[3], res.cmp[2], res.fwd[2],
                       res.cmp[1], res.fwd[1], res.cmp[0], res.fwd[0]};

endmodule

`default_nettype wire

// ===== rtl/fwdm_checker.sv =====
// Port-level checks for the mecanum mixer, bound to the top level.
`default_nettype none

module fwdm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    logic [7:0] pend_reg, pend_next;
    logic       s_acc, m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_comb begin
        pend_next = pend_reg;
        if (s_acc && !m_acc) begin
            pend_next = pend_reg + 1'b1;
        end else if (m_acc && !s_acc) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // a result never shows up without an item behind it
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 8'd0)
        else $error("result item without a pending input item");

    // reset empties the pipe and reopens the input
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipe not empty after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

    // compare values never pass 65536, the largest full period
    a_cmp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[17:1] <= 17'h10000 && m_tdata[35:19] <= 17'h10000
                  && m_tdata[53:37] <= 17'h10000 && m_tdata[71:55] <= 17'h10000)
        else $error("compare value out of range");

endmodule

bind four_wheel_drive_mixer fwdm_checker u_fwdm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
